### hw/rtl/act_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

    // Field widths fixed by the interface
    localparam int TIME_W = 40;
    localparam int ANG_W = 4;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;

    // Default table depth
    localparam int DEF_MAX_CUTS = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_RANGE_END = 2'd1;
    localparam logic [1:0] REG_INIT_ANGLE = 2'd2;
    localparam logic [1:0] REG_MIN_DUR = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_SWITCH = 2'd0,
        FN_QUERY = 2'd1,
        FN_LIST = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_APPLIED = 3'd0,
        ST_NOOP = 3'd1,
        ST_CLOSE = 3'd2,
        ST_RANGE = 3'd3,
        ST_FULL = 3'd4,
        ST_OK = 3'd5
    } st_t;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_FIND_INIT,
        OP_FIND_RD,
        OP_FIND_STEP,
        OP_EMPTY0,
        OP_EMPTY1,
        OP_OVER,
        OP_SHIFT_INIT,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_INSERT,
        OP_MRG_RD0,
        OP_MRG_INIT,
        OP_MRG_RD,
        OP_MRG_STEP,
        OP_MRG_END,
        OP_LIST_INIT,
        OP_LIST_RD,
        OP_LIST_STEP
    } dp_op_t;

    // Which fields a result word carries
    typedef enum logic [2:0] {
        FMT_NONE,
        FMT_QUERY,
        FMT_LIST_EMPTY,
        FMT_LIST_MID,
        FMT_LIST_LAST
    } fmt_t;

    typedef struct packed {
        dp_op_t op;
        logic emit;
        st_t emit_st;
        fmt_t fmt;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic sw_range;
        logic time_out;
        logic list_bad;
        logic count_zero;
        logic find_more;
        logic more;
        logic ptr_zero;
        logic shift_end;
        logic sw_over;
        logic empty_single;
        logic out_busy;
        st_t sw_code;
        st_t empty_code;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/act_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module act_dp #(
    parameter int MAX_CUTS = act_pkg::DEF_MAX_CUTS
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire act_pkg::cmd_t cmd,
    output act_pkg::stat_t stat,
    input wire logic [act_pkg::TIME_W-1:0] range_start,
    input wire logic [act_pkg::TIME_W-1:0] range_end,
    input wire logic [act_pkg::ANG_W-1:0] initial_angle,
    input wire logic [act_pkg::TIME_W-1:0] min_duration,
    input wire logic [act_pkg::FUNC_W-1:0] in_func,
    input wire logic [act_pkg::ANG_W-1:0] in_angle,
    input wire logic [act_pkg::TIME_W-1:0] in_time,
    input wire logic out_ready,
    output logic out_valid,
    output logic [act_pkg::STAT_W-1:0] out_status,
    output logic [act_pkg::ANG_W-1:0] out_angle,
    output logic [act_pkg::TIME_W-1:0] out_start,
    output logic [act_pkg::TIME_W-1:0] out_end,
    output logic out_last
);

    localparam int IW = $clog2(MAX_CUTS);
    localparam int CW = $clog2(MAX_CUTS + 1);
    localparam int TW = act_pkg::TIME_W;
    localparam int AW = act_pkg::ANG_W;

    // Cut table
    logic [TW-1:0] mem_start [MAX_CUTS];
    logic [AW-1:0] mem_angle [MAX_CUTS];

    act_pkg::func_t func_reg;
    logic [AW-1:0] ang_reg;
    logic [TW-1:0] t_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] w_reg, w_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [TW-1:0] ist_reg, ist_next;
    logic [AW-1:0] iang_reg, iang_next;
    logic [TW-1:0] iend_reg, iend_next;
    logic stop_reg, stop_next;
    logic [AW-1:0] last_ang_reg, last_ang_next;
    logic [TW-1:0] cur_start_reg, cur_start_next;
    logic [AW-1:0] cur_angle_reg, cur_angle_next;
    logic [TW-1:0] rd_start_reg;
    logic [AW-1:0] rd_angle_reg;

    logic rd_en;
    logic [IW-1:0] raddr;
    logic wr_en;
    logic [IW-1:0] waddr;
    logic [TW-1:0] wstart;
    logic [AW-1:0] wangle;

    logic range_bad, time_out, near_close, empty_close;
    logic [IW-1:0] idx_plus;

    // Range and time checks
    always_comb begin
        range_bad = (range_end < range_start) || ((range_end - range_start) < min_duration);
        time_out = (t_reg < range_start) || (t_reg >= range_end);
        empty_close = ((t_reg - range_start) < min_duration)
                   || ((range_end - t_reg) < min_duration);
        near_close = (t_reg < ist_reg) || ((t_reg - ist_reg) < min_duration)
                  || (iend_reg < t_reg) || ((iend_reg - t_reg) < min_duration);
        idx_plus = idx_reg + IW'(1);
    end

    // Status toward the controller
    always_comb begin
        stat.func = func_reg;
        stat.sw_range = range_bad || time_out;
        stat.time_out = time_out;
        stat.list_bad = (range_end <= range_start);
        stat.count_zero = (count_reg == '0);
        stat.find_more = !stop_reg && (ptr_reg < count_reg);
        stat.more = (ptr_reg < count_reg);
        stat.ptr_zero = (ptr_reg == '0);
        stat.shift_end = (ptr_reg == (CW'(idx_reg) + CW'(1)));
        stat.out_busy = out_valid;
        stat.empty_single = (t_reg == range_start);
        priority if (ang_reg == initial_angle) begin
            stat.empty_code = act_pkg::ST_NOOP;
        end else if (t_reg == range_start) begin
            stat.empty_code = act_pkg::ST_APPLIED;
        end else if (empty_close) begin
            stat.empty_code = act_pkg::ST_CLOSE;
        end else begin
            stat.empty_code = act_pkg::ST_APPLIED;
        end
        stat.sw_over = (t_reg == ist_reg);
        priority if (iang_reg == ang_reg) begin
            stat.sw_code = act_pkg::ST_NOOP;
        end else if (t_reg == ist_reg) begin
            stat.sw_code = act_pkg::ST_APPLIED;
        end else if (near_close) begin
            stat.sw_code = act_pkg::ST_CLOSE;
        end else if (count_reg >= CW'(MAX_CUTS)) begin
            stat.sw_code = act_pkg::ST_FULL;
        end else begin
            stat.sw_code = act_pkg::ST_APPLIED;
        end
    end

    // Execute the commanded operation
    always_comb begin
        count_next = count_reg;
        ptr_next = ptr_reg;
        w_next = w_reg;
        idx_next = idx_reg;
        ist_next = ist_reg;
        iang_next = iang_reg;
        iend_next = iend_reg;
        stop_next = stop_reg;
        last_ang_next = last_ang_reg;
        cur_start_next = cur_start_reg;
        cur_angle_next = cur_angle_reg;
        rd_en = 1'b0;
        raddr = ptr_reg[IW-1:0];
        wr_en = 1'b0;
        waddr = idx_reg;
        wstart = t_reg;
        wangle = ang_reg;
        unique case (cmd.op)
            act_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            act_pkg::OP_FIND_INIT: begin
                ptr_next = '0;
                stop_next = 1'b0;
                iend_next = range_end;
            end
            act_pkg::OP_FIND_RD, act_pkg::OP_MRG_RD, act_pkg::OP_LIST_RD: begin
                rd_en = 1'b1;
            end
            act_pkg::OP_FIND_STEP: begin
                if (ptr_reg == '0 || rd_start_reg <= t_reg) begin
                    ist_next = rd_start_reg;
                    iang_next = rd_angle_reg;
                    idx_next = ptr_reg[IW-1:0];
                end else begin
                    iend_next = rd_start_reg;
                    stop_next = 1'b1;
                end
                ptr_next = ptr_reg + CW'(1);
            end
            act_pkg::OP_EMPTY0: begin
                wr_en = 1'b1;
                waddr = '0;
                wstart = range_start;
                if (t_reg == range_start) begin
                    wangle = ang_reg;
                    count_next = CW'(1);
                end else begin
                    wangle = initial_angle;
                end
            end
            act_pkg::OP_EMPTY1: begin
                wr_en = 1'b1;
                waddr = IW'(1);
                count_next = CW'(2);
            end
            act_pkg::OP_OVER: begin
                wr_en = 1'b1;
                wstart = ist_reg;
            end
            act_pkg::OP_SHIFT_INIT: begin
                ptr_next = count_reg;
            end
            act_pkg::OP_SHIFT_RD: begin
                rd_en = 1'b1;
                raddr = IW'(ptr_reg - CW'(1));
            end
            act_pkg::OP_SHIFT_WR: begin
                wr_en = 1'b1;
                waddr = ptr_reg[IW-1:0];
                wstart = rd_start_reg;
                wangle = rd_angle_reg;
                ptr_next = ptr_reg - CW'(1);
            end
            act_pkg::OP_INSERT: begin
                wr_en = 1'b1;
                waddr = idx_plus;
                count_next = count_reg + CW'(1);
            end
            act_pkg::OP_MRG_RD0: begin
                rd_en = 1'b1;
                raddr = '0;
                ptr_next = CW'(1);
                w_next = CW'(1);
            end
            act_pkg::OP_MRG_INIT: begin
                last_ang_next = rd_angle_reg;
            end
            act_pkg::OP_MRG_STEP: begin
                // Keep the entry only where the angle changes
                if (rd_angle_reg != last_ang_reg) begin
                    wr_en = 1'b1;
                    waddr = w_reg[IW-1:0];
                    wstart = rd_start_reg;
                    wangle = rd_angle_reg;
                    w_next = w_reg + CW'(1);
                    last_ang_next = rd_angle_reg;
                end
                ptr_next = ptr_reg + CW'(1);
            end
            act_pkg::OP_MRG_END: begin
                count_next = w_reg;
            end
            act_pkg::OP_LIST_INIT: begin
                ptr_next = '0;
            end
            act_pkg::OP_LIST_STEP: begin
                cur_start_next = rd_start_reg;
                cur_angle_next = rd_angle_reg;
                ptr_next = ptr_reg + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Table storage with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_start[waddr] <= wstart;
            mem_angle[waddr] <= wangle;
        end
        if (rd_en) begin
            rd_start_reg <= mem_start[raddr];
            rd_angle_reg <= mem_angle[raddr];
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        ptr_reg <= ptr_next;
        w_reg <= w_next;
        idx_reg <= idx_next;
        ist_reg <= ist_next;
        iang_reg <= iang_next;
        iend_reg <= iend_next;
        stop_reg <= stop_next;
        last_ang_reg <= last_ang_next;
        cur_start_reg <= cur_start_next;
        cur_angle_reg <= cur_angle_next;
        if (cmd.op == act_pkg::OP_LOAD) begin
            func_reg <= act_pkg::func_t'(in_func);
            ang_reg <= in_angle;
            t_reg <= in_time;
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.emit) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
        if (cmd.emit) begin
            out_status <= cmd.emit_st;
            out_last <= 1'b1;
            out_angle <= '0;
            out_start <= '0;
            out_end <= '0;
            unique case (cmd.fmt)
                act_pkg::FMT_QUERY: begin
                    out_angle <= (count_reg == '0) ? initial_angle : iang_reg;
                end
                act_pkg::FMT_LIST_EMPTY: begin
                    out_angle <= initial_angle;
                    out_start <= range_start;
                    out_end <= range_end;
                end
                act_pkg::FMT_LIST_MID: begin
                    out_angle <= cur_angle_reg;
                    out_start <= cur_start_reg;
                    out_end <= rd_start_reg;
                    out_last <= 1'b0;
                end
                act_pkg::FMT_LIST_LAST: begin
                    out_angle <= cur_angle_reg;
                    out_start <= cur_start_reg;
                    out_end <= range_end;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/act_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module act_ctrl (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic in_valid,
    output logic in_ready,
    input wire act_pkg::stat_t stat,
    output act_pkg::cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_DISP = 15'h0002,
        S_FIND_RD = 15'h0004,
        S_FIND_DAT = 15'h0008,
        S_DECIDE = 15'h0010,
        S_EMPTY1 = 15'h0020,
        S_SHIFT_RD = 15'h0040,
        S_SHIFT_WR = 15'h0080,
        S_MRG_RD0 = 15'h0100,
        S_MRG_INIT = 15'h0200,
        S_MRG_RD = 15'h0400,
        S_MRG_DAT = 15'h0800,
        S_LIST_RD = 15'h1000,
        S_LIST_DAT = 15'h2000,
        S_LIST_WAIT = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        in_ready = (state_reg == S_IDLE) && !stat.out_busy;
    end

    // Sequence one item through the table
    always_comb begin
        state_next = state_reg;
        cmd.op = act_pkg::OP_NONE;
        cmd.emit = 1'b0;
        cmd.emit_st = act_pkg::ST_OK;
        cmd.fmt = act_pkg::FMT_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && !stat.out_busy) begin
                    cmd.op = act_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_IDLE;
                unique case (stat.func)
                    act_pkg::FN_SWITCH: begin
                        priority if (stat.sw_range) begin
                            cmd.emit = 1'b1;
                            cmd.emit_st = act_pkg::ST_RANGE;
                        end else if (stat.count_zero) begin
                            if (stat.empty_code != act_pkg::ST_APPLIED) begin
                                cmd.emit = 1'b1;
                                cmd.emit_st = stat.empty_code;
                            end else begin
                                cmd.op = act_pkg::OP_EMPTY0;
                                if (stat.empty_single) begin
                                    cmd.emit = 1'b1;
                                    cmd.emit_st = act_pkg::ST_APPLIED;
                                end else begin
                                    state_next = S_EMPTY1;
                                end
                            end
                        end else begin
                            cmd.op = act_pkg::OP_FIND_INIT;
                            state_next = S_FIND_RD;
                        end
                    end
                    act_pkg::FN_QUERY: begin
                        priority if (stat.time_out) begin
                            cmd.emit = 1'b1;
                            cmd.emit_st = act_pkg::ST_RANGE;
                        end else if (stat.count_zero) begin
                            cmd.emit = 1'b1;
                            cmd.fmt = act_pkg::FMT_QUERY;
                        end else begin
                            cmd.op = act_pkg::OP_FIND_INIT;
                            state_next = S_FIND_RD;
                        end
                    end
                    act_pkg::FN_LIST: begin
                        priority if (stat.list_bad) begin
                            cmd.emit = 1'b1;
                            cmd.emit_st = act_pkg::ST_RANGE;
                        end else if (stat.count_zero) begin
                            cmd.emit = 1'b1;
                            cmd.fmt = act_pkg::FMT_LIST_EMPTY;
                        end else begin
                            cmd.op = act_pkg::OP_LIST_INIT;
                            state_next = S_LIST_RD;
                        end
                    end
                    act_pkg::FN_CLEAR: begin
                        cmd.op = act_pkg::OP_CLEAR;
                        cmd.emit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FIND_RD: begin
                if (stat.find_more) begin
                    cmd.op = act_pkg::OP_FIND_RD;
                    state_next = S_FIND_DAT;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_FIND_DAT: begin
                cmd.op = act_pkg::OP_FIND_STEP;
                state_next = S_FIND_RD;
            end
            S_DECIDE: begin
                priority if (stat.func == act_pkg::FN_QUERY) begin
                    cmd.emit = 1'b1;
                    cmd.fmt = act_pkg::FMT_QUERY;
                    state_next = S_IDLE;
                end else if (stat.sw_code != act_pkg::ST_APPLIED) begin
                    cmd.emit = 1'b1;
                    cmd.emit_st = stat.sw_code;
                    state_next = S_IDLE;
                end else if (stat.sw_over) begin
                    cmd.op = act_pkg::OP_OVER;
                    state_next = S_MRG_RD0;
                end else begin
                    cmd.op = act_pkg::OP_SHIFT_INIT;
                    state_next = S_SHIFT_RD;
                end
            end
            S_EMPTY1: begin
                cmd.op = act_pkg::OP_EMPTY1;
                cmd.emit = 1'b1;
                cmd.emit_st = act_pkg::ST_APPLIED;
                state_next = S_IDLE;
            end
            S_SHIFT_RD: begin
                if (stat.shift_end) begin
                    cmd.op = act_pkg::OP_INSERT;
                    state_next = S_MRG_RD0;
                end else begin
                    cmd.op = act_pkg::OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.op = act_pkg::OP_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_MRG_RD0: begin
                cmd.op = act_pkg::OP_MRG_RD0;
                state_next = S_MRG_INIT;
            end
            S_MRG_INIT: begin
                cmd.op = act_pkg::OP_MRG_INIT;
                state_next = S_MRG_RD;
            end
            S_MRG_RD: begin
                if (stat.more) begin
                    cmd.op = act_pkg::OP_MRG_RD;
                    state_next = S_MRG_DAT;
                end else begin
                    cmd.op = act_pkg::OP_MRG_END;
                    cmd.emit = 1'b1;
                    cmd.emit_st = act_pkg::ST_APPLIED;
                    state_next = S_IDLE;
                end
            end
            S_MRG_DAT: begin
                cmd.op = act_pkg::OP_MRG_STEP;
                state_next = S_MRG_RD;
            end
            S_LIST_RD: begin
                cmd.op = act_pkg::OP_LIST_RD;
                state_next = S_LIST_DAT;
            end
            S_LIST_DAT: begin
                // Emit the previous cut once the next start is known
                cmd.op = act_pkg::OP_LIST_STEP;
                if (!stat.ptr_zero) begin
                    cmd.emit = 1'b1;
                    cmd.fmt = act_pkg::FMT_LIST_MID;
                end
                state_next = S_LIST_WAIT;
            end
            S_LIST_WAIT: begin
                if (!stat.out_busy) begin
                    if (stat.more) begin
                        state_next = S_LIST_RD;
                    end else begin
                        cmd.emit = 1'b1;
                        cmd.fmt = act_pkg::FMT_LIST_LAST;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/angle_cut_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Angle cut table: a time-sorted list of up to MAX_CUTS cut points.
// Input stream s_*: one command word per transfer (switch, query, list, clear).
// Result stream m_*: one word per switch, query or clear; a list gives one word
// per stored cut (one if empty), with m_tlast on the final word of each command.
// APB port: range_start, range_end, initial_angle, min_duration at 8-byte
// steps; write only while the block is idle.
// A command is walked by the sequencer over the single read port of the table
// memory. A query searches the stored cuts; a switch with insert searches,
// then shifts the later entries up, then merges runs of equal angle. Clear
// and commands rejected before the search are answered from the dispatch
// state.
// One command is worked on at a time; s_tready is low while busy or while a
// result word waits in the output register.
// A stalled receiver holds the result word; listing pauses until each word
// is taken. Reset empties the table and zeroes the configuration registers;
// no clearing pass is needed.
module angle_cut_table #(
    parameter int MAX_CUTS = act_pkg::DEF_MAX_CUTS
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    output logic s_tready,
    input wire logic [47:0] s_tdata,  // new_angle[3:0], time_us[43:4], zero pad
    input wire logic [1:0] s_tuser,   // func[1:0]
    output logic m_tvalid,
    input wire logic m_tready,
    output logic [87:0] m_tdata,      // status[2:0], angle_out[6:3],
                                      // span_start[46:7], span_end[86:47], pad
    output logic m_tlast,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [4:0] paddr,
    input wire logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready
);

    localparam int TW = act_pkg::TIME_W;
    localparam int AW = act_pkg::ANG_W;

    logic [TW-1:0] range_start_reg;
    logic [TW-1:0] range_end_reg;
    logic [AW-1:0] init_angle_reg;
    logic [TW-1:0] min_dur_reg;
    logic [1:0] reg_index;

    act_pkg::cmd_t cmd;
    act_pkg::stat_t stat;

    logic [act_pkg::STAT_W-1:0] out_status;
    logic [AW-1:0] out_angle;
    logic [TW-1:0] out_start;
    logic [TW-1:0] out_end;

    assign pready = 1'b1;
    assign reg_index = paddr[4:3];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg <= '0;
            init_angle_reg <= '0;
            min_dur_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_index)
                act_pkg::REG_RANGE_START: range_start_reg <= pwdata[TW-1:0];
                act_pkg::REG_RANGE_END: range_end_reg <= pwdata[TW-1:0];
                act_pkg::REG_INIT_ANGLE: init_angle_reg <= pwdata[AW-1:0];
                act_pkg::REG_MIN_DUR: min_dur_reg <= pwdata[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_index)
            act_pkg::REG_RANGE_START: prdata = {{(64-TW){1'b0}}, range_start_reg};
            act_pkg::REG_RANGE_END: prdata = {{(64-TW){1'b0}}, range_end_reg};
            act_pkg::REG_INIT_ANGLE: prdata = {{(64-AW){1'b0}}, init_angle_reg};
            act_pkg::REG_MIN_DUR: prdata = {{(64-TW){1'b0}}, min_dur_reg};
            default: prdata = '0;
        endcase
    end

    act_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .stat(stat),
        .cmd(cmd)
    );

    act_dp #(
        .MAX_CUTS(MAX_CUTS)
    ) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .stat(stat),
        .range_start(range_start_reg),
        .range_end(range_end_reg),
        .initial_angle(init_angle_reg),
        .min_duration(min_dur_reg),
        .in_func(s_tuser),
        .in_angle(s_tdata[3:0]),
        .in_time(s_tdata[43:4]),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_status(out_status),
        .out_angle(out_angle),
        .out_start(out_start),
        .out_end(out_end),
        .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, out_end, out_start, out_angle, out_status};

endmodule

`default_nettype wire
